// File: hw/rtl/cit_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Connection idle timeout table package
// Operation, phase and configuration register codes shared by the table
// and its ports.
// ----------------------------------------------------------------------------
package cit_pkg;

	typedef logic [2:0] op_t;
	typedef logic [2:0] phase_t;
	typedef logic [1:0] cfg_index_t;
	typedef logic [31:0] limit_t;

	localparam op_t OP_REGISTER   = 3'd0;
	localparam op_t OP_UNREGISTER = 3'd1;
	localparam op_t OP_TOUCH      = 3'd2;
	localparam op_t OP_SET_PHASE  = 3'd3;
	localparam op_t OP_SCAN       = 3'd4;

	localparam phase_t PH_IDLE    = 3'd0;
	localparam phase_t PH_HEADER  = 3'd1;
	localparam phase_t PH_BODY    = 3'd2;
	localparam phase_t PH_WRITING = 3'd3;

	localparam cfg_index_t CFG_HEADER_TIMEOUT    = 2'd0;
	localparam cfg_index_t CFG_BODY_TIMEOUT      = 2'd1;
	localparam cfg_index_t CFG_SEND_TIMEOUT      = 2'd2;
	localparam cfg_index_t CFG_KEEPALIVE_TIMEOUT = 2'd3;

	localparam int SLOT_BITS = 5;

endpackage
`default_nettype wire

// File: hw/rtl/cit_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cit_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                     wdata,
	input  wire logic                                 re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/connection_idle_timeout_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Connection idle timeout table
// Tracks per-slot activity stamps and reports slots that have been inactive
// for at least the limit of their phase.
// ----------------------------------------------------------------------------
// Register, unregister, touch and set-phase transactions may arrive back to
// back. A scan tick walks the phase and stamp memories one slot per cycle
// while the output is not stalled, and holds the input stalled until the scan
// has finished. Expired slots come out in ascending order; the final one of a
// scan carries last.
// ----------------------------------------------------------------------------
module connection_idle_timeout_table #(
	parameter int SLOTS     = 32,
	parameter int TIME_BITS = 48
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire cit_pkg::cfg_index_t   cfg_index,
	input  wire cit_pkg::limit_t       cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire cit_pkg::op_t          op,
	input  wire logic [4:0]            slot,
	input  wire cit_pkg::phase_t       phase,
	input  wire logic [47:0]           now_ms,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [4:0]                 close_slot,
	output logic                       last
);

	import cit_pkg::*;

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(SLOTS - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0]            state_q;
	logic [SLOTS-1:0]      valid_q;
	logic [TIME_BITS-1:0]  cached_q;
	limit_t                header_q;
	limit_t                body_q;
	limit_t                send_q;
	limit_t                keepalive_q;
	logic [AW-1:0]         idx_q;
	logic                  s1_v_s1;
	logic                  s1_live_s1;
	logic [SLOT_BITS-1:0]  s1_idx_s1;
	logic                  pend_v_q;
	logic [SLOT_BITS-1:0]  pend_slot_q;
	logic                  out_valid_q;
	logic [SLOT_BITS-1:0]  out_slot_q;
	logic                  out_last_q;

	logic                  in_acc;
	logic                  in_range;
	logic [AW-1:0]         slot_addr;
	logic                  slot_live;
	logic                  ph_we;
	phase_t                ph_wdata;
	logic                  st_we;
	logic                  advance;
	logic                  rd_en;
	phase_t                ph_rdata;
	logic [TIME_BITS-1:0]  st_rdata;
	limit_t                lim;
	logic [TIME_BITS-1:0]  diff;
	logic                  hit;
	logic                  emit;
	logic                  emit_last;

	assign in_stall   = (state_q != ST_IDLE);
	assign in_acc     = in_valid && !in_stall;
	assign in_range   = {2'b00, slot} < 7'(SLOTS);
	assign slot_addr  = AW'(slot);
	assign slot_live  = valid_q[slot_addr];
	assign advance    = !out_valid_q || !out_stall;
	assign rd_en      = advance && (state_q == ST_SCAN);

	assign ph_we    = in_acc && in_range &&
		((op == OP_REGISTER) || ((op == OP_SET_PHASE) && slot_live));
	assign ph_wdata = (op == OP_REGISTER) ? PH_IDLE : phase;
	assign st_we    = in_acc && in_range &&
		((op == OP_REGISTER) ||
		 (((op == OP_TOUCH) || (op == OP_SET_PHASE)) && slot_live));

	cit_ram #(
		.WIDTH (3),
		.DEPTH (SLOTS)
	) u_phase_ram (
		.clk   (clk),
		.we    (ph_we),
		.waddr (slot_addr),
		.wdata (ph_wdata),
		.re    (rd_en),
		.raddr (idx_q),
		.rdata (ph_rdata)
	);

	cit_ram #(
		.WIDTH (TIME_BITS),
		.DEPTH (SLOTS)
	) u_stamp_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (slot_addr),
		.wdata (cached_q),
		.re    (rd_en),
		.raddr (idx_q),
		.rdata (st_rdata)
	);

	always_comb begin
		case (ph_rdata)
			PH_HEADER:  lim = header_q;
			PH_BODY:    lim = body_q;
			PH_WRITING: lim = send_q;
			default:    lim = keepalive_q;
		endcase
	end

	assign diff = cached_q - st_rdata;
	assign hit  = s1_v_s1 && s1_live_s1 && (lim != '0) &&
		(cached_q >= st_rdata) && (diff >= TIME_BITS'(lim));

	always_comb begin
		emit      = 1'b0;
		emit_last = 1'b0;
		if (advance && hit && pend_v_q) begin
			emit = 1'b1;
		end
		if (advance && (state_q == ST_FLUSH) && pend_v_q) begin
			emit      = 1'b1;
			emit_last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			cached_q    <= '0;
			header_q    <= '0;
			body_q      <= '0;
			send_q      <= '0;
			keepalive_q <= '0;
			idx_q       <= '0;
			s1_v_s1     <= 1'b0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_HEADER_TIMEOUT:    header_q    <= cfg_data;
					CFG_BODY_TIMEOUT:      body_q      <= cfg_data;
					CFG_SEND_TIMEOUT:      send_q      <= cfg_data;
					CFG_KEEPALIVE_TIMEOUT: keepalive_q <= cfg_data;
					default: ;
				endcase
			end

			if (advance) begin
				out_valid_q <= emit;
				if (hit) begin
					pend_v_q <= 1'b1;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						unique case (op)
							OP_REGISTER: begin
								if (in_range) begin
									valid_q[slot_addr] <= 1'b1;
								end
							end
							OP_UNREGISTER: begin
								if (in_range) begin
									valid_q[slot_addr] <= 1'b0;
								end
							end
							OP_SCAN: begin
								cached_q <= TIME_BITS'(now_ms);
								idx_q    <= '0;
								pend_v_q <= 1'b0;
								state_q  <= ST_SCAN;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (advance) begin
						s1_v_s1 <= 1'b1;
						if (idx_q == LAST_IDX) begin
							state_q <= ST_DRAIN;
						end else begin
							idx_q <= idx_q + AW'(1);
						end
					end
				end
				ST_DRAIN: begin
					if (advance) begin
						s1_v_s1 <= 1'b0;
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (advance) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			s1_live_s1 <= valid_q[idx_q];
			s1_idx_s1  <= SLOT_BITS'(idx_q);
		end
		if (advance) begin
			out_slot_q <= pend_slot_q;
			out_last_q <= emit_last;
			if (hit) begin
				pend_slot_q <= s1_idx_s1;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign close_slot = out_slot_q;
	assign last       = out_last_q;

endmodule
`default_nettype wire

// File: sim/tb_connection_idle_timeout_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Connection idle timeout table testbench
// Sends register, unregister, touch, set-phase and scan transactions to the
// table. A local copy of the slot table and the limits predicts the close
// results of each scan without a fixed expectation in the step, and each close
// result is checked in order. A directed table runs first. Random traffic
// follows under several limit settings, in all but one with random gaps on the
// input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb_connection_idle_timeout_table;
	import cit_pkg::*;

	localparam int TABLE_SLOTS   = 32;
	localparam int SETTLE_CYCLES = TABLE_SLOTS + 8;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_ITEMS   = 50;
	localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
	localparam limit_t LIMIT_MAX = 32'hFFFF_FFFF;

	localparam op_t OP_SPARE_A = 3'd5;
	localparam op_t OP_SPARE_B = 3'd6;
	localparam op_t OP_SPARE_C = 3'd7;
	localparam phase_t PH_WEBSOCKET = 3'd4;
	localparam phase_t PH_SPARE     = 3'd7;

	typedef struct packed {
		op_t         op;
		logic [4:0]  slot;
		phase_t      ph;
		logic [47:0] now;
		logic        fixed;
		logic        fixed_hit;
		logic [4:0]  fixed_slot;
	} step_t;

	typedef struct packed {
		logic [4:0] slot;
		logic       last;
	} close_t;

	localparam step_t DIRECTED [0:23] = '{
		'{OP_SCAN,       5'd0,  PH_IDLE,      48'd0,    1'b1, 1'b0, 5'd0},
		'{OP_REGISTER,   5'd0,  PH_IDLE,      48'd0,    1'b0, 1'b0, 5'd0},
		'{OP_REGISTER,   5'd31, PH_IDLE,      48'd0,    1'b0, 1'b0, 5'd0},
		'{OP_SET_PHASE,  5'd31, PH_HEADER,    48'd0,    1'b0, 1'b0, 5'd0},
		'{OP_TOUCH,      5'd5,  PH_IDLE,      48'd0,    1'b0, 1'b0, 5'd0},
		'{OP_SET_PHASE,  5'd6,  PH_BODY,      48'd0,    1'b0, 1'b0, 5'd0},
		'{OP_UNREGISTER, 5'd7,  PH_IDLE,      48'd0,    1'b0, 1'b0, 5'd0},
		'{OP_SCAN,       5'd0,  PH_IDLE,      48'd49,   1'b1, 1'b0, 5'd0},
		'{OP_SCAN,       5'd0,  PH_IDLE,      48'd50,   1'b1, 1'b1, 5'd0},
		'{OP_SPARE_A,    5'd0,  PH_IDLE,      48'd0,    1'b0, 1'b0, 5'd0},
		'{OP_REGISTER,   5'd0,  PH_IDLE,      48'd0,    1'b0, 1'b0, 5'd0},
		'{OP_SCAN,       5'd0,  PH_IDLE,      48'd100,  1'b0, 1'b0, 5'd0},
		'{OP_SET_PHASE,  5'd0,  PH_WRITING,   48'd0,    1'b0, 1'b0, 5'd0},
		'{OP_REGISTER,   5'd16, PH_IDLE,      48'd0,    1'b0, 1'b0, 5'd0},
		'{OP_SET_PHASE,  5'd16, PH_WEBSOCKET, 48'd0,    1'b0, 1'b0, 5'd0},
		'{OP_SET_PHASE,  5'd31, PH_SPARE,     48'd0,    1'b0, 1'b0, 5'd0},
		'{OP_TOUCH,      5'd16, PH_IDLE,      48'd0,    1'b0, 1'b0, 5'd0},
		'{OP_SCAN,       5'd0,  PH_IDLE,      48'd0,    1'b1, 1'b0, 5'd0},
		'{OP_SET_PHASE,  5'd16, PH_BODY,      48'd0,    1'b0, 1'b0, 5'd0},
		'{OP_SCAN,       5'd0,  PH_IDLE,      TIME_MAX, 1'b0, 1'b0, 5'd0},
		'{OP_UNREGISTER, 5'd31, PH_IDLE,      48'd0,    1'b0, 1'b0, 5'd0},
		'{OP_SPARE_B,    5'd31, PH_IDLE,      48'd0,    1'b0, 1'b0, 5'd0},
		'{OP_SPARE_C,    5'd16, PH_IDLE,      48'd0,    1'b0, 1'b0, 5'd0},
		'{OP_SCAN,       5'd0,  PH_IDLE,      TIME_MAX, 1'b0, 1'b0, 5'd0}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	cfg_index_t  cfg_index;
	limit_t      cfg_data;
	logic        in_valid;
	logic        in_stall;
	op_t         op;
	logic [4:0]  slot;
	phase_t      phase;
	logic [47:0] now_ms;
	logic        out_valid;
	logic        out_stall;
	logic [4:0]  close_slot;
	logic        last;

	logic        slot_live [TABLE_SLOTS];
	phase_t      slot_mode [TABLE_SLOTS];
	logic [47:0] slot_seen [TABLE_SLOTS];
	logic [47:0] scan_now;
	limit_t      lim_header;
	limit_t      lim_body;
	limit_t      lim_send;
	limit_t      lim_keepalive;
	close_t      pending_closes [$];
	logic [47:0] clock_ms;
	int          errors;
	bit          idle_on;
	bit          hold_req;

	connection_idle_timeout_table dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.slot       (slot),
		.phase      (phase),
		.now_ms     (now_ms),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.close_slot (close_slot),
		.last       (last)
	);

	always #4 clk = ~clk;

	function automatic limit_t phase_limit(input phase_t p);
		case (p)
			PH_HEADER:  return lim_header;
			PH_BODY:    return lim_body;
			PH_WRITING: return lim_send;
			default:    return lim_keepalive;
		endcase
	endfunction

	function automatic logic [47:0] rand_time();
		logic [63:0] wide;
		wide = {$urandom, $urandom};
		return wide[47:0];
	endfunction

	function automatic logic [47:0] next_scan_time(input limit_t span);
		int          r;
		logic [63:0] step;
		r = $urandom_range(0, 15);
		if (r == 0) begin
			clock_ms = rand_time();
		end else if (r == 1) begin
			clock_ms = clock_ms - $urandom_range(0, 100);
		end else begin
			step = $urandom_range(0, span);
			clock_ms = clock_ms + step[47:0];
		end
		return clock_ms;
	endfunction

	function automatic limit_t pick_limit();
		if ($urandom_range(0, 3) == 0)
			return '0;
		return $urandom_range(1, 150);
	endfunction

	task automatic track_transaction(input step_t s, input bit record);
		close_t hits [$];
		close_t hit;
		limit_t lim;
		if (s.op == OP_SCAN) begin
			scan_now = s.now;
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				lim = phase_limit(slot_mode[i]);
				if (slot_live[i] && lim != 0 && scan_now >= slot_seen[i]
				    && scan_now - slot_seen[i] >= {16'd0, lim}) begin
					hit.slot = i[4:0];
					hit.last = 1'b0;
					hits.push_back(hit);
				end
			end
			if (hits.size() > 0)
				hits[hits.size() - 1].last = 1'b1;
			if (record)
				foreach (hits[i])
					pending_closes.push_back(hits[i]);
		end else begin
			case (s.op)
				OP_REGISTER: begin
					slot_live[s.slot] = 1'b1;
					slot_seen[s.slot] = scan_now;
					slot_mode[s.slot] = PH_IDLE;
				end
				OP_UNREGISTER: slot_live[s.slot] = 1'b0;
				OP_TOUCH: begin
					if (slot_live[s.slot])
						slot_seen[s.slot] = scan_now;
				end
				OP_SET_PHASE: begin
					if (slot_live[s.slot]) begin
						slot_seen[s.slot] = scan_now;
						slot_mode[s.slot] = s.ph;
					end
				end
				default: ;
			endcase
		end
	endtask

	task automatic offer(input step_t s);
		int     gap;
		close_t hit;
		gap = idle_on ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= s.op;
		slot     <= s.slot;
		phase    <= s.ph;
		now_ms   <= s.now;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		track_transaction(s, !s.fixed);
		if (s.fixed && s.fixed_hit) begin
			hit.slot = s.fixed_slot;
			hit.last = 1'b1;
			pending_closes.push_back(hit);
		end
	endtask

	task automatic drain_and_settle();
		in_valid <= 1'b0;
		while (pending_closes.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_limits(input limit_t h, input limit_t b, input limit_t sd,
	                          input limit_t k);
		cfg_index_t idx [4];
		limit_t     vals [4];
		idx[0] = CFG_HEADER_TIMEOUT;
		idx[1] = CFG_BODY_TIMEOUT;
		idx[2] = CFG_SEND_TIMEOUT;
		idx[3] = CFG_KEEPALIVE_TIMEOUT;
		vals[0] = h;
		vals[1] = b;
		vals[2] = sd;
		vals[3] = k;
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		lim_header    = h;
		lim_body      = b;
		lim_send      = sd;
		lim_keepalive = k;
	endtask

	task automatic random_phase(input limit_t h, input limit_t b, input limit_t sd,
	                            input limit_t k, input bit gaps, input bit squeeze);
		step_t  s;
		int     n;
		int     r;
		limit_t span;
		set_limits(h, b, sd, k);
		idle_on  = gaps;
		hold_req = squeeze;
		span = h;
		if (b > span)
			span = b;
		if (sd > span)
			span = sd;
		if (k > span)
			span = k;
		if (span == 0)
			span = 1000;
		n = 0;
		while (n < PHASE_ITEMS) begin
			r = $urandom_range(0, 99);
			s = '0;
			s.slot = 5'($urandom_range(0, TABLE_SLOTS - 1));
			s.ph   = phase_t'($urandom_range(0, 7));
			s.now  = rand_time();
			if (r < 25) begin
				s.op = OP_REGISTER;
			end else if (r < 35) begin
				s.op = OP_UNREGISTER;
			end else if (r < 55) begin
				s.op = OP_TOUCH;
			end else if (r < 75) begin
				s.op = OP_SET_PHASE;
			end else if (r < 95) begin
				s.op  = OP_SCAN;
				s.now = next_scan_time(span);
			end else begin
				case ($urandom_range(0, 2))
					0:       s.op = OP_SPARE_A;
					1:       s.op = OP_SPARE_B;
					default: s.op = OP_SPARE_C;
				endcase
			end
			offer(s);
			if (s.op <= OP_SCAN)
				n++;
		end
		drain_and_settle();
	endtask

	initial begin : close_monitor
		int     rx_wait;
		int     hold_cnt;
		bit     hold_taken;
		close_t want;
		rx_wait    = 0;
		hold_cnt   = 0;
		hold_taken = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (pending_closes.size() == 0) begin
					$error("unexpected close result: close_slot %0d last %0b",
					       close_slot, last);
					errors++;
				end else begin
					want = pending_closes.pop_front();
					if (close_slot !== want.slot) begin
						$error("close_slot expected %0d actual %0d", want.slot, close_slot);
						errors++;
					end
					if (last !== want.last) begin
						$error("last expected %0b actual %0b", want.last, last);
						errors++;
					end
				end
				rx_wait = idle_on ? $urandom_range(0, 12) : 0;
			end
			if (!hold_req) begin
				hold_taken = 1'b0;
			end else if (!hold_taken && out_valid) begin
				hold_cnt   = HOLD_CYCLES;
				hold_taken = 1'b1;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else if (rx_wait > 0) begin
				if (out_valid)
					rx_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		errors   = 0;
		idle_on  = 1'b1;
		hold_req = 1'b1;
		clock_ms = '0;
		scan_now = '0;
		lim_header    = '0;
		lim_body      = '0;
		lim_send      = '0;
		lim_keepalive = '0;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			slot_live[i] = 1'b0;
			slot_mode[i] = PH_IDLE;
			slot_seen[i] = '0;
		end
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_HEADER_TIMEOUT;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		op        <= OP_REGISTER;
		slot      <= '0;
		phase     <= PH_IDLE;
		now_ms    <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_limits(32'd100, 32'd200, 32'd300, 32'd50);
		for (int i = 0; i < $size(DIRECTED); i++)
			offer(DIRECTED[i]);
		drain_and_settle();
		random_phase(pick_limit(), pick_limit(), pick_limit(), pick_limit(), 1'b1, 1'b1);
		random_phase(LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, 1'b1, 1'b0);
		random_phase('0, '0, '0, '0, 1'b1, 1'b0);
		random_phase(pick_limit(), pick_limit(), pick_limit(), pick_limit(), 1'b0, 1'b0);
		random_phase($urandom_range(1, 40), $urandom_range(1, 80), 32'd1,
		             $urandom_range(1, 120), 1'b1, 1'b0);
		if (errors == 0) begin
			$display("PASS connection_idle_timeout_table");
		end else begin
			$display("FAIL connection_idle_timeout_table");
		end
		$finish;
	end

	initial begin : watchdog
		#4_000_000;
		$display("FAIL connection_idle_timeout_table");
		$finish;
	end

endmodule
